FILE: src/jdc_pkg.sv
// jdc_pkg: shared types, constants and the month start table for the
// julian date to calendar unit. no dependencies.
`default_nettype none

package jdc_pkg;

   localparam int FRACTION_BITS = 32;
   localparam int DAY_BITS      = 24;
   localparam int Z_BITS        = DAY_BITS + 1;
   localparam int SEC_PER_DAY   = 86400;
   localparam int SECS_BITS     = 17;
   localparam int GREG_START    = 2299161;
   localparam int GREG_BASE     = 1867216;
   localparam int B_OFFSET      = 1524;
   localparam int YEAR_BASE     = 4715;

   typedef struct packed {
      logic signed [DAY_BITS-1:0]   julian_day;
      logic [FRACTION_BITS-1:0]     day_fraction;
   } jdc_req_type;

   typedef struct packed {
      logic        era_bce;
      logic [14:0] year;
      logic [3:0]  month;
      logic [5:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } jdc_rsp_type;

   typedef struct packed {
      logic signed [15:0] cent;
      logic [3:0]         mon_idx;
      logic [8:0]         day_rest;
   } jdc_date_type;

   typedef struct packed {
      logic       day_carry;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } jdc_time_type;

   // floor(30.6001 * e)
   function automatic logic [8:0] month_start(input logic [3:0] e);
      logic [8:0] res;
      case (e)
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd183;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd244;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd336;
         4'd12:   res = 9'd367;
         4'd13:   res = 9'd397;
         4'd14:   res = 9'd428;
         4'd15:   res = 9'd459;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: src/julian_date_to_calendar_unit.sv
// julian_date_to_calendar_unit: top level, half-day offset, valid pipeline
// and final calendar assembly. depends on jdc_pkg, jdc_date_pipe, jdc_time_pipe.
// throughput: one request per cycle; busy stays low, the receiver cannot stall.
// rate is set by seven register stages, each at most one multiply deep.
// reset clears the valid stages only; requests in flight are dropped.
`default_nettype none

module julian_date_to_calendar_unit import jdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  jdc_req_type req_data,
   output logic        busy,
   output logic        rsp_strobe,
   output jdc_rsp_type rsp_data
);

   logic                     accept;
   logic signed [Z_BITS-1:0] z_num;
   logic [FRACTION_BITS-1:0] tod;
   logic [5:0]               valid_in, valid_ff;
   logic                     rsp_strobe_ff;
   jdc_rsp_type              rsp_in, rsp_ff;
   jdc_date_type             date_w;
   jdc_time_type             time_w;
   logic [3:0]               month_in;
   logic                     late;
   logic signed [16:0]       year_astro, year_mag;
   logic [8:0]               day_full;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // half-day offset with carry into the day count
   assign z_num = Z_BITS'(req_data.julian_day)
                + {{(Z_BITS-1){1'b0}}, req_data.day_fraction[FRACTION_BITS-1]};
   assign tod   = {~req_data.day_fraction[FRACTION_BITS-1],
                   req_data.day_fraction[FRACTION_BITS-2:0]};

   jdc_date_pipe u_date (
      .clock    (clock),
      .day_num  (z_num),
      .date_out (date_w)
   );

   jdc_time_pipe u_time (
      .clock    (clock),
      .tod      (tod),
      .time_out (time_w)
   );

   assign valid_in = {valid_ff[4:0], accept};

   // final assembly
   assign month_in   = (date_w.mon_idx > 4'd13) ? date_w.mon_idx - 4'd13
                                                : date_w.mon_idx - 4'd1;
   assign late       = month_in > 4'd2;
   assign year_astro = 17'(date_w.cent) - 17'(YEAR_BASE) - {16'd0, late};
   assign year_mag   = (year_astro < 17'sd1) ? 17'sd1 - year_astro : year_astro;
   assign day_full   = date_w.day_rest - month_start(date_w.mon_idx)
                     + {8'd0, time_w.day_carry};

   always_comb begin
      rsp_in.era_bce = year_astro < 17'sd1;
      rsp_in.year    = year_mag[14:0];
      rsp_in.month   = month_in;
      rsp_in.day     = day_full[5:0];
      rsp_in.hour    = time_w.hour;
      rsp_in.minute  = time_w.minute;
      rsp_in.second  = time_w.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         rsp_strobe_ff <= valid_ff[5];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##7 rsp_strobe)
      else $error("request lost in pipeline");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 7))
      else $error("response without request");

   a_month: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.month >= 4'd1 && rsp_data.month <= 4'd12))
      else $error("month out of range");

   a_clock: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.hour <= 5'd23 && rsp_data.minute <= 6'd59
                      && rsp_data.second <= 6'd59))
      else $error("time of day out of range");

   a_midnight: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.day == 6'd32) |->
         (rsp_data.hour == 5'd0 && rsp_data.minute == 6'd0 && rsp_data.second == 6'd0))
      else $error("day 32 without midnight carry");
`endif

endmodule

`default_nettype wire

FILE: src/jdc_time_pipe.sv
// jdc_time_pipe: six-stage time of day path, fraction of day to rounded
// hour, minute, second and day carry. depends on jdc_pkg.
`default_nettype none

module jdc_time_pipe import jdc_pkg::*; (
   input  logic                     clock,
   input  logic [FRACTION_BITS-1:0] tod,
   output jdc_time_type             time_out
);

   localparam int SCALE_BITS = FRACTION_BITS + SECS_BITS;
   localparam int HOUR_SHIFT = 29;
   localparam int MIN_SHIFT  = 23;
   localparam int PROD_BITS  = SECS_BITS + 18;
   localparam logic [17:0] HOUR_MUL = 18'(((longint'(1) << HOUR_SHIFT) + 3599) / 3600);
   localparam logic [17:0] MIN_MUL  = 18'(((longint'(1) << MIN_SHIFT) + 59) / 60);
   localparam logic [FRACTION_BITS-1:0] HALF = {1'b1, {(FRACTION_BITS-1){1'b0}}};

   logic [SCALE_BITS-1:0] scaled_in, scaled_ff;
   logic [SECS_BITS-1:0]  secs_in, secs_ff;
   logic                  round_up;
   logic [PROD_BITS-1:0]  hprod, mprod;
   logic [4:0]            hour_in, hour_ff;
   logic [10:0]           mtot_in, mtot_ff;
   logic [SECS_BITS-1:0]  secs3_ff;
   logic [SECS_BITS-1:0]  sec_full;
   logic [10:0]           min_full;
   jdc_time_type          t4_in, t4_ff, t5_ff, t6_ff;

   // stage 1: scale to seconds
   assign scaled_in = SCALE_BITS'(tod) * SCALE_BITS'(SEC_PER_DAY);

   // stage 2: round to nearest, exact half rounds down
   assign round_up = scaled_ff[FRACTION_BITS-1:0] > HALF;
   assign secs_in  = scaled_ff[SCALE_BITS-1:FRACTION_BITS] + {{(SECS_BITS-1){1'b0}}, round_up};

   // stage 3: hours and total minutes by reciprocal
   assign hprod   = PROD_BITS'(secs_ff) * PROD_BITS'(HOUR_MUL);
   assign mprod   = PROD_BITS'(secs_ff) * PROD_BITS'(MIN_MUL);
   assign hour_in = hprod[HOUR_SHIFT+4:HOUR_SHIFT];
   assign mtot_in = mprod[MIN_SHIFT+10:MIN_SHIFT];

   // stage 4: remainders and day carry
   assign sec_full = secs3_ff - (SECS_BITS'(mtot_ff) << 6) + (SECS_BITS'(mtot_ff) << 2);
   assign min_full = mtot_ff - (11'(hour_ff) << 6) + (11'(hour_ff) << 2);

   always_comb begin
      t4_in.day_carry = hour_ff >= 5'd24;
      t4_in.hour      = t4_in.day_carry ? 5'd0 : hour_ff;
      t4_in.minute    = min_full[5:0];
      t4_in.second    = sec_full[5:0];
   end

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      secs_ff   <= secs_in;
      hour_ff   <= hour_in;
      mtot_ff   <= mtot_in;
      secs3_ff  <= secs_ff;
      t4_ff     <= t4_in;
      t5_ff     <= t4_ff;
      t6_ff     <= t5_ff;
   end

   assign time_out = t6_ff;

endmodule

`default_nettype wire

FILE: src/jdc_date_pipe.sv
// jdc_date_pipe: six-stage calendar path, day number to century count,
// month index and day remainder. depends on jdc_pkg.
`default_nettype none

module jdc_date_pipe import jdc_pkg::*; (
   input  logic                     clock,
   input  logic signed [Z_BITS-1:0] day_num,
   output jdc_date_type             date_out
);

   localparam int     ALPHA_SHIFT = 43;
   localparam longint ALPHA_DIV   = 146097;
   localparam logic [25:0] ALPHA_MUL =
      26'(((longint'(1) << ALPHA_SHIFT) + ALPHA_DIV - 1) / ALPHA_DIV);
   localparam int     CENT_SHIFT  = 42;
   localparam longint CENT_DIV    = 7305;
   localparam int     CENT_BIAS   = 23000;
   // (100*b - 12210) / 36525 reduced by 5, biased to stay positive
   localparam logic signed [29:0] CENT_OFS = 30'(7305 * CENT_BIAS - 2442);
   localparam logic [29:0] CENT_MUL =
      30'(((longint'(1) << CENT_SHIFT) + CENT_DIV - 1) / CENT_DIV);
   localparam int     MON_SHIFT   = 32;
   localparam logic [27:0] MON_MUL =
      28'((((longint'(1) << MON_SHIFT) * 10000) + 306000) / 306001);

   logic                     greg_in, greg_ff, greg2_ff;
   logic signed [Z_BITS-1:0] z1_ff, z2_ff;
   logic signed [Z_BITS-1:0] nal_diff;
   logic [24:0]              nal_in, nal_ff;
   logic [50:0]              aprod_in, aprod_ff;
   logic [7:0]               alpha;
   logic signed [9:0]        corr;
   logic signed [Z_BITS-1:0] b_in, b3_ff, b4_ff;
   logic signed [29:0]       n_wide;
   logic [28:0]              n_ff;
   logic [58:0]              cprod_in, cprod_ff;
   logic signed [15:0]       cent_in, cent5_ff, cent6_ff;
   logic signed [26:0]       cd_prod, d_val, rest_wide;
   logic [8:0]               rest_in, rest5_ff, rest6_ff;
   logic [36:0]              eprod;
   logic [3:0]               e_in, e6_ff;

   // stage 1: gregorian test and 4*(z - 1867216) - 1
   assign greg_in  = day_num >= Z_BITS'(GREG_START);
   assign nal_diff = day_num - Z_BITS'(GREG_BASE + 1);
   assign nal_in   = {nal_diff[22:0], 2'b11};

   // stage 2: alpha by reciprocal
   assign aprod_in = 51'(nal_ff) * 51'(ALPHA_MUL);

   // stage 3: b and century numerator
   assign alpha  = aprod_ff[ALPHA_SHIFT+7:ALPHA_SHIFT];
   assign corr   = greg2_ff ? signed'(10'd1 + 10'(alpha) - 10'(alpha[7:2])) : 10'sd0;
   assign b_in   = z2_ff + Z_BITS'(corr) + Z_BITS'(B_OFFSET);
   assign n_wide = (30'(b_in) <<< 4) + (30'(b_in) <<< 2) + CENT_OFS;

   // stage 4: century count by reciprocal
   assign cprod_in = 59'(n_ff) * 59'(CENT_MUL);

   // stage 5: unbias, day of year remainder
   assign cent_in   = signed'(cprod_ff[CENT_SHIFT+15:CENT_SHIFT] - 16'(CENT_BIAS));
   assign cd_prod   = 27'(cent_in) * 27'sd1461;
   assign d_val     = cd_prod >>> 2;
   assign rest_wide = 27'(b4_ff) - d_val;
   assign rest_in   = rest_wide[8:0];

   // stage 6: month index
   assign eprod = 37'(rest5_ff) * 37'(MON_MUL);
   assign e_in  = eprod[MON_SHIFT+3:MON_SHIFT];

   always_ff @(posedge clock) begin
      greg_ff  <= greg_in;
      z1_ff    <= day_num;
      nal_ff   <= nal_in;
      greg2_ff <= greg_ff;
      z2_ff    <= z1_ff;
      aprod_ff <= aprod_in;
      b3_ff    <= b_in;
      n_ff     <= n_wide[28:0];
      b4_ff    <= b3_ff;
      cprod_ff <= cprod_in;
      cent5_ff <= cent_in;
      rest5_ff <= rest_in;
      cent6_ff <= cent5_ff;
      rest6_ff <= rest5_ff;
      e6_ff    <= e_in;
   end

   assign date_out.cent     = cent6_ff;
   assign date_out.mon_idx  = e6_ff;
   assign date_out.day_rest = rest6_ff;

endmodule

`default_nettype wire
